>>> design/ogrm_pkg.sv
// Package for the occupancy grid ray marker: payload types, codes and the sine table function.
package ogrm_pkg;

	// command codes
	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_BEAM  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// cell codes
	localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
	localparam logic [1:0] CELL_FREE     = 2'd1;
	localparam logic [1:0] CELL_OCCUPIED = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_START_ANGLE = 3'd0;
	localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
	localparam logic [2:0] REG_MIN_RANGE   = 3'd2;
	localparam logic [2:0] REG_MAX_RANGE   = 3'd3;
	localparam logic [2:0] REG_CELL_SIZE   = 3'd4;
	localparam logic [2:0] REG_RAY_STEP    = 3'd5;

	// divider dividend width (magnitude of distance*trig >> 15)
	localparam int DIV_W = 17;

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] range_mm;
		logic [6:0]  cell_x;
		logic [6:0]  cell_y;
	} ogrm_cmd_t;

	typedef struct packed {
		logic [1:0] cell_state;
		logic       beam_used;
		logic       hit_in_map;
	} ogrm_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_CENTER,
		ST_IDLE,
		ST_IDX,
		ST_ROM,
		ST_TRIG,
		ST_SAMPLE,
		ST_MUL,
		ST_DIV,
		ST_AXIS,
		ST_WRITE,
		ST_READ,
		ST_DONE
	} ogrm_state_t;

	// Q1.15 sine of a 32-bit phase, degree-11 Taylor in Q30 (elaboration only)
	function automatic logic signed [15:0] sine_f(longint unsigned p);
		longint unsigned quad;
		longint unsigned r;
		longint unsigned t;
		longint unsigned t2;
		longint unsigned h;
		longint unsigned s;
		longint unsigned v;
		quad = (p >> 30) & 64'd3;
		r = p & (Q30_ONE - 64'd1);
		if (quad[0]) begin
			r = Q30_ONE - r;
		end
		t = (r * HALF_PI_Q30) >> 30;
		t2 = (t * t) >> 30;
		h = Q30_ONE;
		h = Q30_ONE - ((t2 * h) >> 30) / 110;
		h = Q30_ONE - ((t2 * h) >> 30) / 72;
		h = Q30_ONE - ((t2 * h) >> 30) / 42;
		h = Q30_ONE - ((t2 * h) >> 30) / 20;
		h = Q30_ONE - ((t2 * h) >> 30) / 6;
		s = (t * h) >> 30;
		v = (s * 64'd32768 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return (quad >= 64'd2) ? -$signed(16'(v)) : $signed(16'(v));
	endfunction

endpackage

>>> design/occupancy_grid_ray_marker.sv
// Occupancy grid ray marker top level: sequencer, shared multiplier and divider, grid memory.
// Reset: a clearing pass writes every grid cell unknown; no commands are taken during it.
// Begin: same clearing pass, then the center cell is written free, then the response.
// Beam: sine and cosine are looked up, then each ray sample (free samples and the hit) is
//   computed by one shared multiplier and a 17-step restoring divider run twice per sample.
// Read: the grid cell is read. Invalid beam or unused command: response only. One command at a time.
module occupancy_grid_ray_marker
	import ogrm_pkg::*;
#(
	parameter int GRID_WIDTH   = 128,
	parameter int GRID_HEIGHT  = 128,
	parameter int SINE_ENTRIES = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  ogrm_cmd_t  cmd,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output ogrm_rsp_t  rsp,
	input  logic       cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(GRID_WIDTH);
	localparam int YW    = $clog2(GRID_HEIGHT);
	localparam int KW    = $clog2(SINE_ENTRIES);
	localparam int CW    = $clog2(DIV_W);
	localparam logic [AW-1:0] LAST_ADDR   = AW'(DEPTH - 1);
	localparam logic [AW-1:0] CENTER_ADDR =
		AW'((GRID_HEIGHT / 2) * GRID_WIDTH + (GRID_WIDTH / 2));
	localparam logic signed [19:0] HALF_W = 20'(GRID_WIDTH / 2);
	localparam logic signed [19:0] HALF_H = 20'(GRID_HEIGHT / 2);
	localparam logic signed [19:0] LIM_W  = 20'(GRID_WIDTH);
	localparam logic signed [19:0] LIM_H  = 20'(GRID_HEIGHT);

	// configuration registers
	logic [15:0] start_angle_q, angle_step_q, min_range_q, max_range_q;
	logic [9:0]  cell_size_q, ray_step_q;
	logic [9:0]  cs_eff, st_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= 16'd0;
			angle_step_q  <= 16'd182;
			min_range_q   <= 16'd0;
			max_range_q   <= 16'd10000;
			cell_size_q   <= 10'd100;
			ray_step_q    <= 10'd100;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_START_ANGLE: start_angle_q <= cfg_data;
				REG_ANGLE_STEP:  angle_step_q  <= cfg_data;
				REG_MIN_RANGE:   min_range_q   <= cfg_data;
				REG_MAX_RANGE:   max_range_q   <= cfg_data;
				REG_CELL_SIZE:   cell_size_q   <= cfg_data[9:0];
				REG_RAY_STEP:    ray_step_q    <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cs_eff = (cell_size_q == 10'd0) ? 10'd1 : cell_size_q;
	assign st_eff = (ray_step_q == 10'd0) ? 10'd1 : ray_step_q;

	// sine ROM built at elaboration
	logic signed [15:0] sine_rom [SINE_ENTRIES];
	for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_rom
		localparam longint unsigned PH = (64'(g) << 32) / SINE_ENTRIES;
		assign sine_rom[g] = sine_f(PH);
	end

	// grid memory
	logic [1:0]    grid_mem [DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [1:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [1:0]    rd_data_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= grid_mem[mem_raddr];
	end

	// sequencer and datapath registers
	ogrm_state_t state_q, state_d;
	logic                 accept;
	logic                 begin_q;
	logic [AW-1:0]        clr_q;
	logic [15:0]          beam_angle_q;
	logic [15:0]          range_q;
	logic                 phase_q;
	logic [KW-1:0]        k_q;
	logic signed [15:0]   rom_q, sin_q, cos_q;
	logic [16:0]          r_q;
	logic [16:0]          d_q;
	logic [1:0]           mark_q;
	logic                 last_q;
	logic                 axis_q;
	logic                 neg_q;
	logic [DIV_W-1:0]     dvd_q;
	logic [9:0]           rem_q;
	logic [CW-1:0]        cnt_q;
	logic signed [19:0]   x_q, y_q;
	logic                 rd_in_q;
	ogrm_rsp_t            res_q;
	ogrm_rsp_t            rsp_q;
	logic                 rsp_valid_q;

	// shared multiplier
	logic signed [17:0] mul_a, mul_b;
	logic signed [35:0] prod;
	logic [15:0]        ang_sel;

	assign ang_sel = phase_q ? (beam_angle_q + 16'd16384) : beam_angle_q;

	always_comb begin
		mul_a = 18'sd0;
		mul_b = 18'sd0;
		case (state_q)
			ST_IDX: begin
				mul_a = $signed({2'b00, ang_sel});
				mul_b = $signed(18'(SINE_ENTRIES));
			end
			ST_MUL: begin
				mul_a = $signed({1'b0, d_q});
				mul_b = axis_q ? 18'(sin_q) : 18'(cos_q);
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;

	// divider step
	logic [10:0] trial;
	logic        qbit;
	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign qbit  = (trial >= {1'b0, cs_eff});

	// floor quotient and cell coordinate
	logic signed [19:0] quo_s, coord;
	assign quo_s = neg_q ? ~$signed({3'b000, dvd_q}) : $signed({3'b000, dvd_q});
	assign coord = quo_s + (axis_q ? HALF_H : HALF_W);

	// bounds and address of the sample cell
	logic          in_grid;
	logic [AW-1:0] cell_addr;
	assign in_grid = !x_q[19] && (x_q < LIM_W) && !y_q[19] && (y_q < LIM_H);
	assign cell_addr = AW'(AW'(y_q[YW-1:0]) * AW'(GRID_WIDTH)) + AW'(x_q[XW-1:0]);

	// read command bounds and address
	logic rd_in;
	assign rd_in = (11'(cmd.cell_x) < 11'(GRID_WIDTH)) && (11'(cmd.cell_y) < 11'(GRID_HEIGHT));
	assign mem_raddr = AW'(AW'(cmd.cell_y) * AW'(GRID_WIDTH)) + AW'(cmd.cell_x);

	logic beam_ok, more_free, rsp_free;
	assign beam_ok   = (cmd.range_mm >= min_range_q) && (cmd.range_mm <= max_range_q);
	assign more_free = (r_q + {7'd0, st_eff}) < {1'b0, range_q};
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;

	// next state and memory write port
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = CELL_UNKNOWN;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == LAST_ADDR) begin
					state_d = begin_q ? ST_CENTER : ST_IDLE;
				end
			end
			ST_CENTER: begin
				mem_we    = 1'b1;
				mem_waddr = CENTER_ADDR;
				mem_wdata = CELL_FREE;
				state_d   = ST_DONE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (cmd.command)
						CMD_BEGIN: state_d = ST_CLEAR;
						CMD_BEAM:  state_d = beam_ok ? ST_IDX : ST_DONE;
						CMD_READ:  state_d = ST_READ;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_IDX:    state_d = ST_ROM;
			ST_ROM:    state_d = ST_TRIG;
			ST_TRIG:   state_d = phase_q ? ST_SAMPLE : ST_IDX;
			ST_SAMPLE: state_d = ST_MUL;
			ST_MUL:    state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CW'(DIV_W - 1)) begin
					state_d = ST_AXIS;
				end
			end
			ST_AXIS:   state_d = axis_q ? ST_WRITE : ST_MUL;
			ST_WRITE: begin
				mem_we    = in_grid;
				mem_waddr = cell_addr;
				mem_wdata = mark_q;
				state_d   = last_q ? ST_DONE : ST_SAMPLE;
			end
			ST_READ:   state_d = ST_DONE;
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			begin_q      <= 1'b0;
			clr_q        <= '0;
			beam_angle_q <= 16'd0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= (clr_q == LAST_ADDR) ? '0 : clr_q + AW'(1);
			end
			if (accept) begin
				begin_q <= (cmd.command == CMD_BEGIN);
				if (cmd.command == CMD_BEGIN) begin
					beam_angle_q <= start_angle_q;
				end
				if (cmd.command == CMD_BEAM && !beam_ok) begin
					beam_angle_q <= beam_angle_q + angle_step_q;
				end
			end
			if (state_q == ST_WRITE && last_q) begin
				beam_angle_q <= beam_angle_q + angle_step_q;
			end
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				range_q <= cmd.range_mm;
				rd_in_q <= rd_in;
				phase_q <= 1'b0;
				res_q   <= '0;
				if (accept && cmd.command == CMD_BEAM && beam_ok) begin
					res_q.beam_used <= 1'b1;
				end
			end
			ST_IDX: k_q <= prod[16 +: KW];
			ST_ROM: rom_q <= sine_rom[k_q];
			ST_TRIG: begin
				if (phase_q) begin
					cos_q <= rom_q;
					r_q   <= {1'b0, min_range_q};
				end else begin
					sin_q   <= rom_q;
					phase_q <= 1'b1;
				end
			end
			ST_SAMPLE: begin
				axis_q <= 1'b0;
				if (more_free) begin
					d_q    <= r_q;
					mark_q <= CELL_FREE;
					last_q <= 1'b0;
				end else begin
					d_q    <= {1'b0, range_q};
					mark_q <= CELL_OCCUPIED;
					last_q <= 1'b1;
				end
			end
			ST_MUL: begin
				// floor(p / 2^15) then floor by cell size; negative values divide their complement
				neg_q <= prod[35];
				dvd_q <= prod[35] ? ~prod[31:15] : prod[31:15];
				rem_q <= 10'd0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= qbit ? 10'(trial - {1'b0, cs_eff}) : trial[9:0];
				dvd_q <= {dvd_q[DIV_W-2:0], qbit};
				cnt_q <= cnt_q + CW'(1);
			end
			ST_AXIS: begin
				if (axis_q) begin
					y_q <= coord;
				end else begin
					x_q <= coord;
				end
				axis_q <= !axis_q;
			end
			ST_WRITE: begin
				r_q <= r_q + {7'd0, st_eff};
				if (last_q) begin
					res_q.hit_in_map <= in_grid;
				end
			end
			ST_READ: res_q.cell_state <= rd_in_q ? rd_data_q : CELL_UNKNOWN;
			ST_DONE: begin
				if (rsp_free) begin
					rsp_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> design/ogrm_checker.sv
// Port-level checker for the occupancy grid ray marker and its bind.
module ogrm_checker
	import ogrm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_stall,
	input ogrm_cmd_t  cmd,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input ogrm_rsp_t  rsp
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// a command transfer makes the block busy in the following cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("input ready right after a transfer");

	// a marked hit only comes from a traced beam
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit_in_map |-> rsp.beam_used)
		else $error("hit without beam");

	// a cell state only comes from a read
	a_cell: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.cell_state != CELL_UNKNOWN) |->
			!rsp.beam_used && (rsp.cell_state == CELL_FREE || rsp.cell_state == CELL_OCCUPIED))
		else $error("bad cell state");

endmodule

bind occupancy_grid_ray_marker ogrm_checker u_ogrm_checker (.*);
